// ===== sv/rcs_pkg.sv =====
// Shared types and constants for the rotary cycle sequencer.
// No dependencies; imported by rotary_cycle_sequencer_top.
package rcs_pkg;

    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;
    localparam int WAIT_W              = 12;
    localparam int SEG_W               = 16;
    localparam int DEB_W               = 8;
    localparam int THR_W               = 16;
    localparam int DUTY_W              = 8;
    localparam int COUNTER_BITS        = 32;
    localparam int DEBOUNCE_COUNT_BITS = 16;
    localparam int ELAPSED_W           = 32;
    localparam int CODE_W              = 3;
    localparam int NUM_SENSORS         = 4;
    localparam int COUNT_OUT_W         = 32;
    localparam int MS_PER_SEC          = 1000;
    localparam int WAIT_LIMIT_W        = 22;

    localparam int SEN_HOME   = 0;
    localparam int SEN_DUMP   = 1;
    localparam int SEN_WEIGHT = 2;
    localparam int SEN_BUTTON = 3;

    localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(300);
    localparam logic [SEG_W-1:0]  SEG_RESET  = SEG_W'(15000);
    localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(25);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(10);
    localparam logic [DUTY_W-1:0] DUTY_RESET = DUTY_W'(220);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAIT_TIME     = 3'd0,
        REG_SEG_TIMEOUT   = 3'd1,
        REG_DEBOUNCE      = 3'd2,
        REG_DRAWER_THRESH = 3'd3,
        REG_MOTOR_DUTY    = 3'd4
    } cfg_index_t;

    typedef enum logic [7:0] {
        S_HOMING   = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_OCCUPIED = 8'b0000_0100,
        S_WAITING  = 8'b0000_1000,
        S_TO_DUMP  = 8'b0001_0000,
        S_TO_HOME  = 8'b0010_0000,
        S_SAFETY   = 8'b0100_0000,
        S_FAULT    = 8'b1000_0000
    } state_t;

    localparam logic [CODE_W-1:0] CODE_HOMING   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_IDLE     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_OCCUPIED = 3'd2;
    localparam logic [CODE_W-1:0] CODE_WAITING  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_TO_DUMP  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_TO_HOME  = 3'd5;
    localparam logic [CODE_W-1:0] CODE_SAFETY   = 3'd6;
    localparam logic [CODE_W-1:0] CODE_FAULT    = 3'd7;

    typedef struct packed {
        logic home_raw;
        logic dump_raw;
        logic weight_raw;
        logic button_raw;
        logic cycle_request;
        logic fault_reset_request;
        logic drawer_emptied_request;
    } tick_t;

    typedef struct packed {
        logic [CODE_W-1:0]      controller_state;
        logic                   motor_run;
        logic [DUTY_W-1:0]      motor_duty;
        logic                   occupied;
        logic                   drawer_limit_hit;
        logic [COUNT_OUT_W-1:0] total_cycle_count;
        logic [COUNT_OUT_W-1:0] drawer_cycle_count;
        logic                   cycle_completed;
    } result_t;

    function automatic logic [CODE_W-1:0] state_code(input state_t s);
        logic [CODE_W-1:0] c;
        unique case (s)
            S_HOMING:   c = CODE_HOMING;
            S_IDLE:     c = CODE_IDLE;
            S_OCCUPIED: c = CODE_OCCUPIED;
            S_WAITING:  c = CODE_WAITING;
            S_TO_DUMP:  c = CODE_TO_DUMP;
            S_TO_HOME:  c = CODE_TO_HOME;
            S_SAFETY:   c = CODE_SAFETY;
            default:    c = CODE_FAULT;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/rotary_cycle_sequencer_top.sv =====
// Rotary cycle sequencer: debounce, cycle controller, counters and result register.
// Depends on rcs_pkg.
// An accepted tick is registered in tick_reg, then in result_reg on advance.
// Throughput: one transaction per cycle; the tick register advances whenever
// the result register is empty or being drained in the same cycle.
// Reset: asynchronous, active low; controller returns to homing, counters clear,
// config registers take their default values.
module rotary_cycle_sequencer_top
    import rcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_ready,
    input  tick_t                 tick,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [WAIT_LIMIT_W-1:0] wait_limit_reg;
    logic [SEG_W-1:0]        seg_timeout_reg;
    logic [DEB_W-1:0]        debounce_reg;
    logic [THR_W-1:0]        threshold_reg;
    logic [DUTY_W-1:0]       duty_reg;

    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    state_t                   state_reg, state_next;
    logic                     resume_reg, resume_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic                     motor_reg, motor_next;
    logic                     cycle_pending_reg, cycle_pending_next;
    logic                     reset_pending_reg, reset_pending_next;
    logic [COUNTER_BITS-1:0]  total_reg, total_next;
    logic [COUNTER_BITS-1:0]  drawer_reg, drawer_next;
    logic [NUM_SENSORS-1:0]   stable_reg, stable_next;
    logic [NUM_SENSORS-1:0]   last_reg, last_next;
    logic [DEBOUNCE_COUNT_BITS-1:0] since_reg [NUM_SENSORS];
    logic [DEBOUNCE_COUNT_BITS-1:0] since_next [NUM_SENSORS];
    result_t                  result_next;

    assign advance      = tick_valid_reg && (!result_valid_reg || result_ready);
    assign tick_ready   = !tick_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        logic [NUM_SENSORS-1:0]   raw;
        logic                     weight_on;
        logic                     home_on;
        logic                     dump_on;
        logic                     button_on;
        logic [ELAPSED_W-1:0]     elapsed_inc;
        logic                     restart;
        logic                     completed;
        logic [COUNTER_BITS-1:0]  drawer_tmp;

        raw = {tick_reg.button_raw, tick_reg.weight_raw, tick_reg.dump_raw, tick_reg.home_raw};
        last_next   = last_reg;
        stable_next = stable_reg;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            since_next[i] = since_reg[i];
            if (raw[i] != last_reg[i])
            begin
                last_next[i]  = raw[i];
                since_next[i] = '0;
            end
            else if (since_reg[i] != '1)
            begin
                since_next[i] = since_reg[i] + 1'b1;
            end
            if (since_next[i] > DEBOUNCE_COUNT_BITS'(debounce_reg))
            begin
                stable_next[i] = last_next[i];
            end
        end

        home_on   = !stable_next[SEN_HOME];
        dump_on   = !stable_next[SEN_DUMP];
        weight_on = !stable_next[SEN_WEIGHT];
        button_on = !stable_next[SEN_BUTTON];

        cycle_pending_next = cycle_pending_reg | tick_reg.cycle_request;
        reset_pending_next = reset_pending_reg | tick_reg.fault_reset_request;

        elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;

        state_next  = state_reg;
        motor_next  = motor_reg;
        resume_next = resume_reg;
        total_next  = total_reg;
        drawer_tmp  = drawer_reg;
        restart     = 1'b0;
        completed   = 1'b0;

        if ((state_reg == S_TO_DUMP || state_reg == S_TO_HOME) && weight_on)
        begin
            motor_next  = 1'b0;
            resume_next = (state_reg == S_TO_HOME);
            state_next  = S_SAFETY;
            restart     = 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_HOMING:
                begin
                    motor_next = 1'b1;
                    if (home_on)
                    begin
                        motor_next = 1'b0;
                        state_next = S_IDLE;
                        restart    = 1'b1;
                    end
                    else if (elapsed_inc > ELAPSED_W'({seg_timeout_reg, 1'b0}))
                    begin
                        motor_next = 1'b0;
                        state_next = S_FAULT;
                        restart    = 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (weight_on)
                    begin
                        state_next = S_OCCUPIED;
                        restart    = 1'b1;
                    end
                    else if (cycle_pending_next || button_on)
                    begin
                        cycle_pending_next = 1'b0;
                        motor_next         = 1'b1;
                        state_next         = S_TO_DUMP;
                        restart            = 1'b1;
                    end
                end
                S_OCCUPIED:
                begin
                    if (!weight_on)
                    begin
                        state_next = S_WAITING;
                        restart    = 1'b1;
                    end
                end
                S_WAITING:
                begin
                    if (weight_on)
                    begin
                        state_next = S_OCCUPIED;
                        restart    = 1'b1;
                    end
                    else if (elapsed_inc >= ELAPSED_W'(wait_limit_reg))
                    begin
                        motor_next = 1'b1;
                        state_next = S_TO_DUMP;
                        restart    = 1'b1;
                    end
                end
                S_TO_DUMP:
                begin
                    if (dump_on)
                    begin
                        state_next = S_TO_HOME;
                        restart    = 1'b1;
                    end
                    else if (elapsed_inc > ELAPSED_W'(seg_timeout_reg))
                    begin
                        motor_next = 1'b0;
                        state_next = S_FAULT;
                        restart    = 1'b1;
                    end
                end
                S_TO_HOME:
                begin
                    if (home_on)
                    begin
                        motor_next = 1'b0;
                        total_next = total_reg + 1'b1;
                        drawer_tmp = drawer_reg + 1'b1;
                        completed  = 1'b1;
                        state_next = S_IDLE;
                        restart    = 1'b1;
                    end
                    else if (elapsed_inc > ELAPSED_W'(seg_timeout_reg))
                    begin
                        motor_next = 1'b0;
                        state_next = S_FAULT;
                        restart    = 1'b1;
                    end
                end
                S_SAFETY:
                begin
                    if (!weight_on)
                    begin
                        motor_next = 1'b1;
                        state_next = resume_reg ? S_TO_HOME : S_TO_DUMP;
                        restart    = 1'b1;
                    end
                end
                default:
                begin
                    motor_next = 1'b0;
                    if (reset_pending_next)
                    begin
                        reset_pending_next = 1'b0;
                        state_next         = S_HOMING;
                        restart            = 1'b1;
                    end
                end
            endcase
        end

        elapsed_next = restart ? '0 : elapsed_inc;
        drawer_next  = tick_reg.drawer_emptied_request ? '0 : drawer_tmp;

        result_next.controller_state   = state_code(state_next);
        result_next.motor_run          = motor_next;
        result_next.motor_duty         = motor_next ? duty_reg : '0;
        result_next.occupied           = weight_on;
        result_next.drawer_limit_hit   = (drawer_next >= COUNTER_BITS'(threshold_reg));
        result_next.total_cycle_count  = COUNT_OUT_W'(total_next);
        result_next.drawer_cycle_count = COUNT_OUT_W'(drawer_next);
        result_next.cycle_completed    = completed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_limit_reg  <= WAIT_LIMIT_W'(WAIT_RESET) * WAIT_LIMIT_W'(MS_PER_SEC);
            seg_timeout_reg <= SEG_RESET;
            debounce_reg    <= DEB_RESET;
            threshold_reg   <= THR_RESET;
            duty_reg        <= DUTY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAIT_TIME:
                    wait_limit_reg <= WAIT_LIMIT_W'(cfg_data[WAIT_W-1:0])
                                      * WAIT_LIMIT_W'(MS_PER_SEC);
                REG_SEG_TIMEOUT:   seg_timeout_reg <= cfg_data[SEG_W-1:0];
                REG_DEBOUNCE:      debounce_reg    <= cfg_data[DEB_W-1:0];
                REG_DRAWER_THRESH: threshold_reg   <= cfg_data[THR_W-1:0];
                REG_MOTOR_DUTY:    duty_reg        <= cfg_data[DUTY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_ready)
            begin
                tick_valid_reg <= tick_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            tick_reg <= tick;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_HOMING;
            resume_reg        <= 1'b0;
            elapsed_reg       <= '0;
            motor_reg         <= 1'b0;
            cycle_pending_reg <= 1'b0;
            reset_pending_reg <= 1'b0;
            total_reg         <= '0;
            drawer_reg        <= '0;
            stable_reg        <= '1;
            last_reg          <= '1;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                since_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            state_reg         <= state_next;
            resume_reg        <= resume_next;
            elapsed_reg       <= elapsed_next;
            motor_reg         <= motor_next;
            cycle_pending_reg <= cycle_pending_next;
            reset_pending_reg <= reset_pending_next;
            total_reg         <= total_next;
            drawer_reg        <= drawer_next;
            stable_reg        <= stable_next;
            last_reg          <= last_next;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                since_reg[i] <= since_next[i];
            end
        end
    end

    a_motor_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TO_DUMP || state_reg == S_TO_HOME) |-> motor_reg)
        else $error("motor stopped inside a drum segment");

    a_completed_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.cycle_completed)
            |-> (result_reg.controller_state == CODE_IDLE && !result_reg.motor_run))
        else $error("cycle completion reported outside idle");

    a_total_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !result_next.cycle_completed) |=> $stable(total_reg))
        else $error("total count moved without a completed cycle");

    a_stopped_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.motor_run) |-> (result_reg.motor_duty == '0))
        else $error("nonzero duty with motor stopped");

endmodule
